@@ rtl/pipwa_pkg.sv @@
// ----------------------------------------------------------------------------
// pipwa_pkg: shared types and constants for the winding-angle polygon test
// Holds the coordinate and angle widths, the CORDIC arctangent table, the
// controller state type and the command/status bundles between the modules.
// ----------------------------------------------------------------------------
package pipwa_pkg;

  // Coordinate and angle widths
  localparam int COORD_W    = 32;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int ANGLE_BITS = 16;
  localparam int PRESCALE   = 60 - COORD_W;
  localparam int CORDIC_W   = 64;
  localparam int ITER_W     = $clog2(ANGLE_BITS);
  localparam int ZW         = 32;
  localparam int SUM_W      = 32;
  localparam int DELTA_W    = ANGLE_BITS + 2;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ITER,
    ST_ACCUM,
    ST_CLOSE,
    ST_EMIT
  } pipwa_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic iter;
    logic accum;
    logic close;
    logic emit;
  } pipwa_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic iter_done;
    logic last;
    logic out_busy;
  } pipwa_sts_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [ZW-1:0] atan_lut(input logic [ITER_W-1:0] idx);
    logic [ZW-1:0] v;
    case (idx)
      4'd0:    v = 32'h20000000;
      4'd1:    v = 32'h12E4051E;
      4'd2:    v = 32'h09FB385B;
      4'd3:    v = 32'h051111D4;
      4'd4:    v = 32'h028B0D43;
      4'd5:    v = 32'h0145D7E1;
      4'd6:    v = 32'h00A2F61E;
      4'd7:    v = 32'h00517C55;
      4'd8:    v = 32'h0028BE53;
      4'd9:    v = 32'h00145F2F;
      4'd10:   v = 32'h000A2F98;
      4'd11:   v = 32'h000517CC;
      4'd12:   v = 32'h00028BE6;
      4'd13:   v = 32'h000145F3;
      4'd14:   v = 32'h0000A2F9;
      4'd15:   v = 32'h0000517D;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/pipwa_ctrl.sv @@
// ----------------------------------------------------------------------------
// pipwa_ctrl: sequencing controller
// Steps each vertex through capture, CORDIC setup, sixteen vectoring
// iterations and accumulation; closes the ring and emits on the last vertex.
// ----------------------------------------------------------------------------
module pipwa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  pipwa_pkg::pipwa_sts_t sts,
  output pipwa_pkg::pipwa_cmd_t cmd,
  output logic                  in_stall
);

  pipwa_pkg::pipwa_state_t state_r;
  pipwa_pkg::pipwa_state_t state_nxt;

  // Hold the current state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pipwa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance through the per-vertex sequence
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pipwa_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = pipwa_pkg::ST_PREP;
      end
      pipwa_pkg::ST_PREP: begin
        state_nxt = pipwa_pkg::ST_ITER;
      end
      pipwa_pkg::ST_ITER: begin
        if (sts.iter_done) state_nxt = pipwa_pkg::ST_ACCUM;
      end
      pipwa_pkg::ST_ACCUM: begin
        state_nxt = sts.last ? pipwa_pkg::ST_CLOSE : pipwa_pkg::ST_IDLE;
      end
      pipwa_pkg::ST_CLOSE: begin
        state_nxt = pipwa_pkg::ST_EMIT;
      end
      pipwa_pkg::ST_EMIT: begin
        if (!sts.out_busy) state_nxt = pipwa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pipwa_pkg::ST_IDLE;
      end
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      pipwa_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      pipwa_pkg::ST_PREP:  cmd.prep  = 1'b1;
      pipwa_pkg::ST_ITER:  cmd.iter  = 1'b1;
      pipwa_pkg::ST_ACCUM: cmd.accum = 1'b1;
      pipwa_pkg::ST_CLOSE: cmd.close = 1'b1;
      pipwa_pkg::ST_EMIT:  cmd.emit  = !sts.out_busy;
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

@@ rtl/pipwa_dp.sv @@
// ----------------------------------------------------------------------------
// pipwa_dp: bearing and turn-sum datapath
// Computes the point-to-vertex bearing with an iterative CORDIC vectoring
// unit, accumulates wrapped bearing differences and holds the result register.
// ----------------------------------------------------------------------------
module pipwa_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pipwa_pkg::pipwa_cmd_t               cmd,
  output pipwa_pkg::pipwa_sts_t               sts,
  input  logic signed [pipwa_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [pipwa_pkg::COORD_W-1:0] in_point_y,
  input  logic signed [pipwa_pkg::COORD_W-1:0] in_vertex_x,
  input  logic signed [pipwa_pkg::COORD_W-1:0] in_vertex_y,
  input  logic                                in_last_vertex,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_inside_res
);

  localparam int CW = pipwa_pkg::CORDIC_W;
  localparam int DW = pipwa_pkg::DIFF_W;
  localparam int AB = pipwa_pkg::ANGLE_BITS;
  localparam int EXT_W = CW - DW - pipwa_pkg::PRESCALE;
  localparam int SIGN_W = pipwa_pkg::SUM_W - pipwa_pkg::DELTA_W;

  logic signed [DW-1:0]              dx_r, dy_r;
  logic                              last_r;
  logic signed [CW-1:0]              x_r, y_r;
  logic [pipwa_pkg::ZW-1:0]          z_r;
  logic [pipwa_pkg::ITER_W-1:0]      i_r;
  logic [AB-1:0]                     first_r, prev_r;
  logic [pipwa_pkg::SUM_W-1:0]       sum_r;
  logic                              started_r;
  logic                              out_valid_r;
  logic                              out_inside_r;

  logic signed [CW-1:0]              x_pre, y_pre;
  logic signed [CW-1:0]              x_sh, y_sh;
  logic                              y_pos;
  logic [AB-1:0]                     bearing;
  logic [AB-1:0]                     diff_to;
  logic signed [pipwa_pkg::DELTA_W-1:0] delta;
  logic [pipwa_pkg::SUM_W-1:0]       sum_nxt;
  logic signed [pipwa_pkg::SUM_W-1:0] sum_s;
  logic                              is_inside;

  // Prescale the differences into the CORDIC word
  assign x_pre = {{EXT_W{dy_r[DW-1]}}, dy_r, {pipwa_pkg::PRESCALE{1'b0}}};
  assign y_pre = {{EXT_W{dx_r[DW-1]}}, dx_r, {pipwa_pkg::PRESCALE{1'b0}}};

  // Shift terms for the current iteration
  assign x_sh  = x_r >>> i_r;
  assign y_sh  = y_r >>> i_r;
  assign y_pos = !y_r[CW-1] && (y_r != '0);

  // Round the turn fraction, or take the vertical axis directly
  always_comb begin
    if (dx_r == '0) begin
      bearing = dy_r[DW-1] ? {1'b1, {(AB-1){1'b0}}} : '0;
    end else begin
      bearing = z_r[pipwa_pkg::ZW-1 -: AB] + {{(AB-1){1'b0}}, z_r[pipwa_pkg::ZW-AB-1]};
    end
  end

  // Wrap the bearing difference into one half turn either way
  assign diff_to = cmd.close ? first_r : bearing;
  always_comb begin
    delta = $signed({2'b00, diff_to}) - $signed({2'b00, prev_r});
    if (delta > $signed(pipwa_pkg::DELTA_W'(1 << (AB - 1)))) begin
      delta = delta - $signed(pipwa_pkg::DELTA_W'(1 << AB));
    end else if (delta < -$signed(pipwa_pkg::DELTA_W'(1 << (AB - 1)))) begin
      delta = delta + $signed(pipwa_pkg::DELTA_W'(1 << AB));
    end
  end
  assign sum_nxt = sum_r - {{SIGN_W{delta[pipwa_pkg::DELTA_W-1]}}, delta};

  // Decide inside when the turn magnitude reaches half a turn
  assign sum_s     = $signed(sum_r);
  assign is_inside = (sum_s >= $signed(pipwa_pkg::SUM_W'(1 << (AB - 1)))) ||
                     (sum_s <= -$signed(pipwa_pkg::SUM_W'(1 << (AB - 1))));

  // Capture the vertex and run the CORDIC unit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r   <= $signed({in_vertex_x[pipwa_pkg::COORD_W-1], in_vertex_x}) -
                $signed({in_point_x[pipwa_pkg::COORD_W-1], in_point_x});
      dy_r   <= $signed({in_vertex_y[pipwa_pkg::COORD_W-1], in_vertex_y}) -
                $signed({in_point_y[pipwa_pkg::COORD_W-1], in_point_y});
      last_r <= in_last_vertex;
    end
    if (cmd.prep) begin
      i_r <= '0;
      if (dy_r[DW-1]) begin
        x_r <= -x_pre;
        y_r <= -y_pre;
        z_r <= {1'b1, {(pipwa_pkg::ZW-1){1'b0}}};
      end else begin
        x_r <= x_pre;
        y_r <= y_pre;
        z_r <= '0;
      end
    end
    if (cmd.iter) begin
      i_r <= i_r + 1'b1;
      if (y_pos) begin
        x_r <= x_r + y_sh;
        y_r <= y_r - x_sh;
        z_r <= z_r + pipwa_pkg::atan_lut(i_r);
      end else begin
        x_r <= x_r - y_sh;
        y_r <= y_r + x_sh;
        z_r <= z_r - pipwa_pkg::atan_lut(i_r);
      end
    end
  end

  // Accumulate turns, close the ring and load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r      <= '0;
      prev_r       <= '0;
      sum_r        <= '0;
      started_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.accum) begin
        prev_r <= bearing;
        if (!started_r) begin
          first_r   <= bearing;
          sum_r     <= '0;
          started_r <= 1'b1;
        end else begin
          sum_r <= sum_nxt;
        end
      end
      if (cmd.close) begin
        sum_r  <= sum_nxt;
        prev_r <= first_r;
      end
      if (cmd.emit) begin
        out_inside_r <= is_inside;
        sum_r        <= '0;
        started_r    <= 1'b0;
      end
    end
  end

  // Report status
  assign sts.iter_done = (i_r == pipwa_pkg::ITER_W'(AB - 1));
  assign sts.last      = last_r;
  assign sts.out_busy  = out_valid_r && out_stall;

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;

endmodule

@@ rtl/point_in_polygon_winding_angle.sv @@
// ----------------------------------------------------------------------------
// point_in_polygon_winding_angle: point-in-polygon test by winding angle
// Streams polygon vertices with the query point and reports whether the point
// lies inside from the summed turn of its bearings to the vertices.
// ----------------------------------------------------------------------------
//
//  channel  ports                                          direction
//  -------  ---------------------------------------------  ---------
//  in       in_valid, in_stall, in_point_x/y,              sink
//           in_vertex_x/y, in_last_vertex
//  out      out_valid, out_stall, out_inside_res           source
//
//  A vertex passes from acceptance to the next acceptance through capture,
//  CORDIC setup, 16 vectoring iterations of the shared shift-add unit, and
//  an accumulate step. A last vertex adds a ring close and a result step.
//  Reset is synchronous and active low; it clears the controller, the
//  polygon-started flag and the result valid flag.
//  A result held under out_stall does not block new vertices; only the next
//  result waits for the output register to drain.
//
module point_in_polygon_winding_angle (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pipwa_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [pipwa_pkg::COORD_W-1:0] in_point_y,
  input  logic signed [pipwa_pkg::COORD_W-1:0] in_vertex_x,
  input  logic signed [pipwa_pkg::COORD_W-1:0] in_vertex_y,
  input  logic                                in_last_vertex,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_inside_res
);

  pipwa_pkg::pipwa_cmd_t cmd;
  pipwa_pkg::pipwa_sts_t sts;

  // Sequence each transaction
  pipwa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // Compute bearings and the turn sum
  pipwa_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_last_vertex (in_last_vertex),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_inside_res (out_inside_res)
  );

endmodule

@@ tb/tb_point_in_polygon_winding_angle.sv @@
// ----------------------------------------------------------------------------
// tb_point_in_polygon_winding_angle: self-checking bench for the winding test
// Streams directed and random polygons into the block, predicts each inside
// flag with a bit-exact CORDIC bearing model and compares every result
// transaction in order. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

typedef struct packed {
  logic signed [pipwa_pkg::COORD_W-1:0] px;
  logic signed [pipwa_pkg::COORD_W-1:0] py;
  logic signed [pipwa_pkg::COORD_W-1:0] vx;
  logic signed [pipwa_pkg::COORD_W-1:0] vy;
  logic                                 last;
} vertex_t;

// atan(2^-i) in units of 2^-32 turn, index 0 first
localparam logic [0:15][31:0] ATAN_TURN = {
  32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
  32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
  32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
  32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D
};

class winding_scoreboard;
  localparam int AB   = pipwa_pkg::ANGLE_BITS;
  localparam int FULL = 1 << AB;
  localparam int HALF = 1 << (AB - 1);

  bit           inside_q[$];
  int           errors;
  int           results_checked;
  int           inside_count;
  logic [AB-1:0] first_bearing;
  logic [AB-1:0] prev_bearing;
  int           turn_sum;
  bit           polygon_open;

  function new();
    errors          = 0;
    results_checked = 0;
    inside_count    = 0;
    first_bearing   = '0;
    prev_bearing    = '0;
    turn_sum        = 0;
    polygon_open    = 1'b0;
  endfunction

  // Compass bearing from the point to the vertex by CORDIC vectoring
  function logic [AB-1:0] bearing_of(longint dx, longint dy);
    longint     x, y, nx, ny;
    logic [31:0] z;
    logic [32:0] r;
    if (dx == 0) return (dy < 0) ? HALF[AB-1:0] : '0;
    x = dy * (64'sd1 <<< pipwa_pkg::PRESCALE);
    y = dx * (64'sd1 <<< pipwa_pkg::PRESCALE);
    z = 32'h0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < AB; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + ATAN_TURN[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - ATAN_TURN[i];
      end
      x = nx;
      y = ny;
    end
    r = {1'b0, z} + (33'd1 << (31 - AB));
    return r[31 -: AB];
  endfunction

  // Subtract the wrapped bearing step from the running turn
  function void add_turn(logic [AB-1:0] from_b, logic [AB-1:0] to_b);
    int d;
    d = int'(to_b) - int'(from_b);
    if (d > HALF) d -= FULL;
    else if (d < -HALF) d += FULL;
    turn_sum = turn_sum - d;
  endfunction

  // Advance the predictor on one accepted vertex transaction
  function void note_vertex(vertex_t v);
    logic [AB-1:0] b;
    longint        mag;
    b = bearing_of(longint'(v.vx) - longint'(v.px), longint'(v.vy) - longint'(v.py));
    if (!polygon_open) begin
      first_bearing = b;
      prev_bearing  = b;
      turn_sum      = 0;
      polygon_open  = 1'b1;
    end else begin
      add_turn(prev_bearing, b);
      prev_bearing = b;
    end
    if (v.last) begin
      add_turn(prev_bearing, first_bearing);
      prev_bearing = first_bearing;
      mag = longint'(turn_sum);
      if (mag < 0) mag = -mag;
      inside_q.push_back(mag >= HALF);
      turn_sum     = 0;
      polygon_open = 1'b0;
    end
  endfunction

  task report(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  // Compare one result transaction with the oldest prediction
  task check_result(logic got);
    bit want;
    if (inside_q.size() == 0) begin
      report($sformatf("result %0d arrived with nothing predicted", results_checked));
    end else begin
      want = inside_q.pop_front();
      if (got !== want)
        report($sformatf("result %0d inside_res got %b want %b", results_checked, got, want));
      if (want) inside_count++;
    end
    results_checked++;
  endtask

  task check_leftover();
    if (inside_q.size() != 0)
      report($sformatf("%0d predicted results never arrived", inside_q.size()));
  endtask
endclass

module tb_point_in_polygon_winding_angle;
  localparam int ITEMS       = 1750;
  localparam int DRAIN       = 40;
  localparam int CYCLE_LIMIT = 250000;
  localparam logic signed [31:0] CMIN = 32'sh80000000;
  localparam logic signed [31:0] CMAX = 32'sh7fffffff;
  localparam logic signed [31:0] U    = 32'sh00010000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [pipwa_pkg::COORD_W-1:0] in_point_x;
  logic signed [pipwa_pkg::COORD_W-1:0] in_point_y;
  logic signed [pipwa_pkg::COORD_W-1:0] in_vertex_x;
  logic signed [pipwa_pkg::COORD_W-1:0] in_vertex_y;
  logic in_last_vertex;
  logic out_valid;
  logic out_stall;
  logic out_inside_res;

  winding_scoreboard sb;
  vertex_t           poly_q[$];
  int                vertex_count  = 0;
  int                polygon_count = 0;
  int                cycle_count   = 0;
  bit                in_quiet      = 1'b0;

  point_in_polygon_winding_angle dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_last_vertex (in_last_vertex),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_inside_res (out_inside_res)
  );

  always #4 clk = ~clk;

  // Count cycles and end a hung run
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("point_in_polygon_winding_angle: mismatch");
    $finish;
  end

  task automatic add_vertex(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] vx, logic signed [31:0] vy);
    vertex_t v;
    v.px   = px;
    v.py   = py;
    v.vx   = vx;
    v.vy   = vy;
    v.last = 1'b0;
    poly_q.push_back(v);
  endtask

  // Drive the queued polygon, one vertex transaction at a time
  task automatic send_polygon();
    vertex_t v;
    int      gap;
    if ($urandom_range(0, 5) == 0) in_quiet = !in_quiet;
    foreach (poly_q[k]) begin
      v      = poly_q[k];
      v.last = (k == poly_q.size() - 1);
      gap    = in_quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid       <= 1'b1;
      in_point_x     <= v.px;
      in_point_y     <= v.py;
      in_vertex_x    <= v.vx;
      in_vertex_y    <= v.vy;
      in_last_vertex <= v.last;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      sb.note_vertex(v);
      vertex_count++;
    end
    poly_q.delete();
    polygon_count++;
  endtask

  // Result side: accept, check, then hold off the next result at random
  initial begin
    int hold;
    bit out_quiet;
    hold      = 0;
    out_quiet = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1) begin
        if (out_valid && !out_stall) begin
          sb.check_result(out_inside_res);
          if ($urandom_range(0, 7) == 0) out_quiet = !out_quiet;
          hold = out_quiet ? 0 : $urandom_range(0, 6);
        end else if (out_valid && hold > 0) begin
          hold--;
        end
        out_stall <= (hold > 0);
      end
    end
  end

  // Stimulus
  initial begin
    int          kind, n, reach, q, start_count;
    bit          dir;
    logic signed [31:0] cx, cy, px, py, ox, oy;
    sb = new();
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_point_x     <= '0;
    in_point_y     <= '0;
    in_vertex_x    <= '0;
    in_vertex_y    <= '0;
    in_last_vertex <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-vertex polygon: no turn, outside
    add_vertex(0, 0, U, 2 * U);
    send_polygon();
    // Two opposite vertices straight above and below: exact half-turn steps
    add_vertex(0, 0, 0, U);
    add_vertex(0, 0, 0, -U);
    send_polygon();
    // Square around the point, counterclockwise then clockwise
    add_vertex(0, 0, U, U);
    add_vertex(0, 0, -U, U);
    add_vertex(0, 0, -U, -U);
    add_vertex(0, 0, U, -U);
    send_polygon();
    add_vertex(5 * U, -7 * U, 6 * U, -6 * U);
    add_vertex(5 * U, -7 * U, 6 * U, -8 * U);
    add_vertex(5 * U, -7 * U, 4 * U, -8 * U);
    add_vertex(5 * U, -7 * U, 4 * U, -6 * U);
    send_polygon();
    // Point well outside a triangle
    add_vertex(10 * U, 0, U, U);
    add_vertex(10 * U, 0, -U, U);
    add_vertex(10 * U, 0, 0, -U);
    send_polygon();
    // Point sitting on a vertex
    add_vertex(U, U, U, U);
    add_vertex(U, U, -U, U);
    add_vertex(U, U, 0, -U);
    send_polygon();
    // Coordinate extremes, vertical bearings both ways
    add_vertex(CMIN, CMIN, CMAX, CMIN);
    add_vertex(CMIN, CMIN, CMAX, CMAX);
    add_vertex(CMIN, CMIN, CMIN, CMAX);
    send_polygon();
    add_vertex(CMAX, CMAX, CMIN, CMAX);
    add_vertex(CMAX, CMAX, CMIN, CMIN);
    add_vertex(CMAX, CMAX, CMAX, CMIN);
    send_polygon();
    // Query point moving within one polygon
    add_vertex(0, 0, U, 0);
    add_vertex(U, U, 3 * U, -U);
    add_vertex(-U, 2 * U, -3 * U, 5 * U);
    send_polygon();

    // Random polygons: mostly star shapes around a center, some noise
    start_count = vertex_count;
    while (vertex_count - start_count < ITEMS) begin
      kind  = $urandom_range(0, 7);
      n     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
      reach = $urandom_range(4, 28);
      dir   = $urandom_range(0, 1);
      cx    = $signed($urandom) >>> 2;
      cy    = $signed($urandom) >>> 2;
      px    = cx;
      py    = cy;
      if (kind >= 4 && kind < 6) begin
        // shift the point clear of the shape
        px = cx + ($urandom_range(0, 1) ? (3 <<< reach) : -(3 <<< reach));
        py = cy + ($signed($urandom) >>> (31 - reach));
      end
      for (int k = 0; k < n; k++) begin
        if (kind >= 6) begin
          if (k == 0 || $urandom_range(0, 2) == 0) begin
            px = $urandom;
            py = $urandom;
          end
          add_vertex(px, py, $urandom, $urandom);
        end else begin
          q  = dir ? (4 * k) / n : 3 - (4 * k) / n;
          ox = $urandom & ((32'd1 << reach) - 1);
          oy = $urandom & ((32'd1 << reach) - 1);
          if (q == 1 || q == 2) ox = -ox;
          if (q >= 2) oy = -oy;
          add_vertex(px, py, cx + ox, cy + oy);
        end
      end
      send_polygon();
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then settle
    while (sb.inside_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    sb.check_leftover();

    $display("ran %0d vertices in %0d polygons over %0d cycles",
             vertex_count, polygon_count, cycle_count);
    $display("checked %0d inside flags, %0d inside, %0d errors",
             sb.results_checked, sb.inside_count, sb.errors);
    if (sb.errors == 0) begin
      $display("point_in_polygon_winding_angle: match");
    end else begin
      $display("point_in_polygon_winding_angle: mismatch");
    end
    $finish;
  end
endmodule
